[src/bssp_pkg.sv]
// ----------------------------------------------------------------------------
// Bisector side sign predicate: shared definitions
// Widths of the stream words, operation codes, side codes and the small
// sign helpers used by the pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bssp_pkg;

  localparam int COORD_BITS_DEF = 20;
  localparam int FIELD_W        = 60;
  localparam int OP_W           = 2;
  localparam int SIDE_W         = 2;
  localparam int IN_TDATA_W     = 424;
  localparam int OUT_TDATA_W    = 8;
  localparam int MUL_CHUNK      = 32;
  localparam int NSTG           = 22;

  localparam logic [OP_W-1:0] OP_VERTEX = 2'd0;
  localparam logic [OP_W-1:0] OP_EDGE   = 2'd1;
  localparam logic [OP_W-1:0] OP_FACET  = 2'd2;

  typedef logic [SIDE_W-1:0] side_t;

  localparam side_t SIDE_ZERO = 2'b00;
  localparam side_t SIDE_POS  = 2'b01;
  localparam side_t SIDE_NEG  = 2'b11;

  function automatic side_t side_of(input logic neg, input logic nz);
    side_t s;
    if (neg) begin
      s = SIDE_NEG;
    end else if (nz) begin
      s = SIDE_POS;
    end else begin
      s = SIDE_ZERO;
    end
    return s;
  endfunction

  function automatic side_t side_mul(input side_t x, input side_t y);
    side_t s;
    if (x == SIDE_ZERO || y == SIDE_ZERO) begin
      s = SIDE_ZERO;
    end else if (x == y) begin
      s = SIDE_POS;
    end else begin
      s = SIDE_NEG;
    end
    return s;
  endfunction

endpackage

`default_nettype wire

[src/bssp_mul.sv]
// ----------------------------------------------------------------------------
// Pipelined signed multiplier
// Splits both operands into chunks of at most 33 signed bits, registers the
// partial products, then the row sums, then the full product.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bssp_mul #(
  parameter int AW = 24,
  parameter int BW = 24
) (
  input  logic                    clk,
  input  logic [2:0]              en,
  input  logic signed [AW-1:0]    a,
  input  logic signed [BW-1:0]    b,
  output logic signed [AW+BW-1:0] p
);
  import bssp_pkg::*;

  localparam int K    = MUL_CHUNK;
  localparam int NA   = (AW + K - 1) / K;
  localparam int NB   = (BW + K - 1) / K;
  localparam int XA   = NA * K;
  localparam int XB   = NB * K;
  localparam int PPW  = 2 * K + 2;
  localparam int ROWW = XA + K + 2;
  localparam int SUMW = XA + XB + 2;

  logic signed [XA-1:0]   ax;
  logic signed [XB-1:0]   bx;
  logic signed [K:0]      ac [NA];
  logic signed [K:0]      bc [NB];
  logic signed [PPW-1:0]  pp [NA][NB];
  logic signed [ROWW-1:0] row_next [NB];
  logic signed [ROWW-1:0] row [NB];
  logic signed [SUMW-1:0] sum_next;

  always_comb begin
    ax = XA'(a);
    bx = XB'(b);
    for (int i = 0; i < NA; i++) begin
      if (i == NA - 1) begin
        ac[i] = $signed({ax[XA-1], ax[i*K +: K]});
      end else begin
        ac[i] = $signed({1'b0, ax[i*K +: K]});
      end
    end
    for (int j = 0; j < NB; j++) begin
      if (j == NB - 1) begin
        bc[j] = $signed({bx[XB-1], bx[j*K +: K]});
      end else begin
        bc[j] = $signed({1'b0, bx[j*K +: K]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp[i][j] <= ac[i] * bc[j];
        end
      end
    end
  end

  always_comb begin
    for (int j = 0; j < NB; j++) begin
      row_next[j] = '0;
      for (int i = 0; i < NA; i++) begin
        row_next[j] = row_next[j] + (ROWW'(pp[i][j]) <<< (K * i));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int j = 0; j < NB; j++) begin
        row[j] <= row_next[j];
      end
    end
  end

  always_comb begin
    sum_next = '0;
    for (int j = 0; j < NB; j++) begin
      sum_next = sum_next + (SUMW'(row[j]) <<< (K * j));
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      p <= sum_next[AW+BW-1:0];
    end
  end

endmodule

`default_nettype wire

[src/bssp_dly.sv]
// ----------------------------------------------------------------------------
// Stalling delay line
// Carries a value alongside the pipeline, one register per stage, each stage
// loading under its own enable.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bssp_dly #(
  parameter int W = 8,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic [N-1:0] en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] r [N];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      r[0] <= d;
    end
  end

  for (genvar i = 1; i < N; i++) begin : g_stg
    always_ff @(posedge clk) begin
      if (en[i]) begin
        r[i] <= r[i-1];
      end
    end
  end

  assign q = r[N-1];

endmodule

`default_nettype wire

[src/bisector_side_sign_predicate.sv]
// ----------------------------------------------------------------------------
// Bisector side sign predicate
// Exact sign of a point against the bisector plane of two sites, for a mesh
// vertex, a bisector-edge crossing or a two-bisector-facet crossing.
// ----------------------------------------------------------------------------
// The block takes one word per cycle whenever s_tready is high and returns
// one result word per input word, in order. The pipeline depth is set by the
// longest chain, the facet case, which runs five multiplier levels in a row;
// each multiplication cuts its operands into 32-bit chunks and takes three
// stages (partial products, row sums, product), with an adder stage between
// levels. A stalled output holds its word while empty stages further up still
// take new words.
`timescale 1ns / 1ps
`default_nettype none

module bisector_side_sign_predicate #(
  parameter int COORD_BITS = bssp_pkg::COORD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // operation, site_a, site_b, site_c, site_d, bound_one, bound_two,
  // bound_three, zero fill
  input  logic [bssp_pkg::IN_TDATA_W-1:0]  s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // side_sign, zero fill
  output logic [bssp_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import bssp_pkg::*;

  localparam int C     = COORD_BITS;
  localparam int XW    = (3 * C > FIELD_W) ? 3 * C : FIELD_W;
  localparam int W1    = C + 3;
  localparam int PW1   = 2 * W1;
  localparam int DW    = 2 * W1 + 2;
  localparam int ERW   = 2 * DW + 1;
  localparam int GW    = W1 + DW + 1;
  localparam int NQW   = W1 + DW + 3;
  localparam int DENW  = W1 + GW + 2;
  localparam int TW    = DW + NQW + 2;
  localparam int TMW   = TW + 1;
  localparam int RSW   = W1 + TMW + 2;
  localparam int PA    = 0;
  localparam int PB    = 1;
  localparam int PC    = 2;
  localparam int PD    = 3;
  localparam int PQ1   = 4;
  localparam int PQ2   = 5;
  localparam int PQ3   = 6;

  logic [NSTG:1] en;
  logic [NSTG:1] v;

  always_comb begin
    en[NSTG] = !v[NSTG] || m_tready;
    for (int k = NSTG - 1; k >= 1; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign s_tready = en[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) begin
        v[1] <= s_tvalid;
      end
      for (int k = 2; k <= NSTG; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // Unpacking of the points
  logic [FIELD_W-1:0]   fld [7];
  logic [XW-1:0]        fx [7];
  logic signed [C-1:0]  pt [7][3];

  always_comb begin
    for (int p = 0; p < 7; p++) begin
      fld[p] = s_tdata[OP_W + p*FIELD_W +: FIELD_W];
      fx[p]  = XW'(fld[p]);
      for (int k = 0; k < 3; k++) begin
        pt[p][k] = fx[p][k*C +: C];
      end
    end
  end

  // Stage 1: coordinate differences and sums
  logic [OP_W-1:0]      op1;
  logic signed [W1-1:0] vv1 [3], vp1 [3], eu1 [3], ef1 [3], es1 [3], et1 [3];
  logic signed [W1-1:0] fe1 [3], ff1 [3], fw1 [3], fsd1 [3], fsc1 [3], fab1 [3];
  logic signed [W1-1:0] fq1 [3];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      op1 <= s_tdata[OP_W-1:0];
      for (int k = 0; k < 3; k++) begin
        vv1[k]  <= W1'(pt[PA][k]) - W1'(pt[PB][k]);
        vp1[k]  <= W1'(pt[PQ1][k]) + W1'(pt[PQ1][k]) - W1'(pt[PA][k]) - W1'(pt[PB][k]);
        eu1[k]  <= W1'(pt[PQ2][k]) - W1'(pt[PQ1][k]);
        ef1[k]  <= W1'(pt[PA][k]) - W1'(pt[PC][k]);
        es1[k]  <= W1'(pt[PC][k]) + W1'(pt[PA][k]) - W1'(pt[PQ1][k]) - W1'(pt[PQ1][k]);
        et1[k]  <= W1'(pt[PQ1][k]) + W1'(pt[PQ1][k]) - W1'(pt[PB][k]) - W1'(pt[PA][k]);
        fe1[k]  <= W1'(pt[PD][k]) - W1'(pt[PA][k]);
        ff1[k]  <= W1'(pt[PC][k]) - W1'(pt[PA][k]);
        fw1[k]  <= W1'(pt[PQ3][k]) - W1'(pt[PQ1][k]);
        fsd1[k] <= W1'(pt[PA][k]) + W1'(pt[PD][k]);
        fsc1[k] <= W1'(pt[PA][k]) + W1'(pt[PC][k]);
        fab1[k] <= W1'(pt[PA][k]) + W1'(pt[PB][k]);
        fq1[k]  <= W1'(pt[PQ1][k]);
      end
    end
  end

  // Stages 2 to 4: first multiplier level
  logic signed [PW1-1:0] mv4 [3], muf4 [3], mvu4 [3], msf4 [3], mvt4 [3];
  logic signed [PW1-1:0] mhd4 [3], mhc4 [3], mna4 [3], mnb4 [3], mka4 [3], mkb4 [3];
  logic signed [W1-1:0]  fe5 [3], ff5 [3], fq5 [3], ff9 [3], fab13 [3], amb17 [3];
  logic [OP_W-1:0]       op21;

  for (genvar k = 0; k < 3; k++) begin : g_l1
    localparam int I1 = (k + 1) % 3;
    localparam int I2 = (k + 2) % 3;
    bssp_mul #(.AW(W1), .BW(W1)) u_mv (.clk, .en(en[4:2]), .a(vv1[k]), .b(vp1[k]), .p(mv4[k]));
    bssp_mul #(.AW(W1), .BW(W1)) u_muf (.clk, .en(en[4:2]), .a(eu1[k]), .b(ef1[k]), .p(muf4[k]));
    bssp_mul #(.AW(W1), .BW(W1)) u_mvu (.clk, .en(en[4:2]), .a(vv1[k]), .b(eu1[k]), .p(mvu4[k]));
    bssp_mul #(.AW(W1), .BW(W1)) u_msf (.clk, .en(en[4:2]), .a(es1[k]), .b(ef1[k]), .p(msf4[k]));
    bssp_mul #(.AW(W1), .BW(W1)) u_mvt (.clk, .en(en[4:2]), .a(vv1[k]), .b(et1[k]), .p(mvt4[k]));
    bssp_mul #(.AW(W1), .BW(W1)) u_mhd (.clk, .en(en[4:2]), .a(fe1[k]), .b(fsd1[k]), .p(mhd4[k]));
    bssp_mul #(.AW(W1), .BW(W1)) u_mhc (.clk, .en(en[4:2]), .a(ff1[k]), .b(fsc1[k]), .p(mhc4[k]));
    bssp_mul #(.AW(W1), .BW(W1)) u_mna (.clk, .en(en[4:2]), .a(eu1[I1]), .b(fw1[I2]), .p(mna4[k]));
    bssp_mul #(.AW(W1), .BW(W1)) u_mnb (.clk, .en(en[4:2]), .a(eu1[I2]), .b(fw1[I1]), .p(mnb4[k]));
    bssp_mul #(.AW(W1), .BW(W1)) u_mka (.clk, .en(en[4:2]), .a(ff1[I1]), .b(fe1[I2]), .p(mka4[k]));
    bssp_mul #(.AW(W1), .BW(W1)) u_mkb (.clk, .en(en[4:2]), .a(ff1[I2]), .b(fe1[I1]), .p(mkb4[k]));

    bssp_dly #(.W(W1), .N(4))  u_dfe (.clk, .en(en[5:2]), .d(fe1[k]), .q(fe5[k]));
    bssp_dly #(.W(W1), .N(4))  u_dff (.clk, .en(en[5:2]), .d(ff1[k]), .q(ff5[k]));
    bssp_dly #(.W(W1), .N(4))  u_dfq (.clk, .en(en[5:2]), .d(fq1[k]), .q(fq5[k]));
    bssp_dly #(.W(W1), .N(8))  u_df9 (.clk, .en(en[9:2]), .d(ff1[k]), .q(ff9[k]));
    bssp_dly #(.W(W1), .N(12)) u_dab (.clk, .en(en[13:2]), .d(fab1[k]), .q(fab13[k]));
    bssp_dly #(.W(W1), .N(16)) u_dmb (.clk, .en(en[17:2]), .d(vv1[k]), .q(amb17[k]));
  end

  bssp_dly #(.W(OP_W), .N(20)) u_dop (.clk, .en(en[21:2]), .d(op1), .q(op21));

  // Stage 5: first dot and cross products
  logic signed [DW-1:0] acc5, eden5, evu5, esf5, evt5, fhd5, fhc5;
  logic signed [DW-1:0] fn5 [3], fk5 [3];

  always_ff @(posedge clk) begin
    if (en[5]) begin
      acc5  <= DW'(mv4[0]) + DW'(mv4[1]) + DW'(mv4[2]);
      eden5 <= DW'(muf4[0]) + DW'(muf4[1]) + DW'(muf4[2]);
      evu5  <= DW'(mvu4[0]) + DW'(mvu4[1]) + DW'(mvu4[2]);
      esf5  <= DW'(msf4[0]) + DW'(msf4[1]) + DW'(msf4[2]);
      evt5  <= DW'(mvt4[0]) + DW'(mvt4[1]) + DW'(mvt4[2]);
      fhd5  <= DW'(mhd4[0]) + DW'(mhd4[1]) + DW'(mhd4[2]);
      fhc5  <= DW'(mhc4[0]) + DW'(mhc4[1]) + DW'(mhc4[2]);
      for (int k = 0; k < 3; k++) begin
        fn5[k] <= DW'(mna4[k]) - DW'(mnb4[k]);
        fk5[k] <= DW'(mka4[k]) - DW'(mkb4[k]);
      end
    end
  end

  // Stages 6 to 8: second multiplier level
  side_t                    sv6, sv21;
  logic signed [2*DW-1:0]   mr1_8, mr2_8;
  logic signed [W1+DW-1:0]  mga8 [3], mgb8 [3], mha8 [3], mhb8 [3], mnq8 [3];
  logic signed [DW-1:0]     eden9, fhd9, fhc9;
  logic signed [DW-1:0]     fk9 [3];

  always_ff @(posedge clk) begin
    if (en[6]) begin
      sv6 <= side_of(acc5[DW-1], |acc5);
    end
  end

  bssp_dly #(.W(SIDE_W), .N(15)) u_dsv (.clk, .en(en[21:7]), .d(sv6), .q(sv21));

  bssp_mul #(.AW(DW), .BW(DW)) u_mr1 (.clk, .en(en[8:6]), .a(evu5), .b(esf5), .p(mr1_8));
  bssp_mul #(.AW(DW), .BW(DW)) u_mr2 (.clk, .en(en[8:6]), .a(evt5), .b(eden5), .p(mr2_8));

  bssp_dly #(.W(DW), .N(4)) u_dden (.clk, .en(en[9:6]), .d(eden5), .q(eden9));
  bssp_dly #(.W(DW), .N(4)) u_dhd (.clk, .en(en[9:6]), .d(fhd5), .q(fhd9));
  bssp_dly #(.W(DW), .N(4)) u_dhc (.clk, .en(en[9:6]), .d(fhc5), .q(fhc9));

  for (genvar k = 0; k < 3; k++) begin : g_l2
    localparam int I1 = (k + 1) % 3;
    localparam int I2 = (k + 2) % 3;
    bssp_mul #(.AW(W1), .BW(DW)) u_mga (.clk, .en(en[8:6]), .a(fe5[I1]), .b(fn5[I2]), .p(mga8[k]));
    bssp_mul #(.AW(W1), .BW(DW)) u_mgb (.clk, .en(en[8:6]), .a(fe5[I2]), .b(fn5[I1]), .p(mgb8[k]));
    bssp_mul #(.AW(W1), .BW(DW)) u_mha (.clk, .en(en[8:6]), .a(ff5[I2]), .b(fn5[I1]), .p(mha8[k]));
    bssp_mul #(.AW(W1), .BW(DW)) u_mhb (.clk, .en(en[8:6]), .a(ff5[I1]), .b(fn5[I2]), .p(mhb8[k]));
    bssp_mul #(.AW(W1), .BW(DW)) u_mnq (.clk, .en(en[8:6]), .a(fq5[k]), .b(fn5[k]), .p(mnq8[k]));
    bssp_dly #(.W(DW), .N(4)) u_dk (.clk, .en(en[9:6]), .d(fk5[k]), .q(fk9[k]));
  end

  // Stage 9
  logic signed [ERW-1:0] eres9;
  logic signed [GW-1:0]  fg9 [3], fh9 [3];
  logic signed [NQW-1:0] fnq9;
  logic signed [NQW-1:0] nq_sum;

  assign nq_sum = NQW'(mnq8[0]) + NQW'(mnq8[1]) + NQW'(mnq8[2]);

  always_ff @(posedge clk) begin
    if (en[9]) begin
      eres9 <= ERW'(mr1_8) + ERW'(mr2_8);
      fnq9  <= nq_sum <<< 1;
      for (int k = 0; k < 3; k++) begin
        fg9[k] <= GW'(mga8[k]) - GW'(mgb8[k]);
        fh9[k] <= GW'(mha8[k]) - GW'(mhb8[k]);
      end
    end
  end

  // Stages 10 to 12: third multiplier level
  side_t                      se10, se21;
  logic signed [W1+GW-1:0]    mfg12 [3];
  logic signed [GW+DW-1:0]    mghc12 [3], mhhd12 [3];
  logic signed [DW+NQW-1:0]   mknq12 [3];

  always_ff @(posedge clk) begin
    if (en[10]) begin
      se10 <= side_mul(side_of(eres9[ERW-1], |eres9), side_of(eden9[DW-1], |eden9));
    end
  end

  bssp_dly #(.W(SIDE_W), .N(11)) u_dse (.clk, .en(en[21:11]), .d(se10), .q(se21));

  for (genvar k = 0; k < 3; k++) begin : g_l3
    bssp_mul #(.AW(W1), .BW(GW)) u_mfg (.clk, .en(en[12:10]), .a(ff9[k]), .b(fg9[k]), .p(mfg12[k]));
    bssp_mul #(.AW(GW), .BW(DW)) u_mghc (.clk, .en(en[12:10]), .a(fg9[k]), .b(fhc9), .p(mghc12[k]));
    bssp_mul #(.AW(GW), .BW(DW)) u_mhhd (.clk, .en(en[12:10]), .a(fh9[k]), .b(fhd9), .p(mhhd12[k]));
    bssp_mul #(.AW(DW), .BW(NQW)) u_mknq (.clk, .en(en[12:10]), .a(fk9[k]), .b(fnq9), .p(mknq12[k]));
  end

  // Stage 13
  logic signed [DENW-1:0] den13, den21;
  logic signed [TW-1:0]   t13 [3], t16 [3];

  always_ff @(posedge clk) begin
    if (en[13]) begin
      den13 <= DENW'(mfg12[0]) + DENW'(mfg12[1]) + DENW'(mfg12[2]);
      for (int k = 0; k < 3; k++) begin
        t13[k] <= TW'(mghc12[k]) + TW'(mhhd12[k]) + TW'(mknq12[k]);
      end
    end
  end

  bssp_dly #(.W(DENW), .N(8)) u_dden2 (.clk, .en(en[21:14]), .d(den13), .q(den21));

  // Stages 14 to 16: fourth multiplier level
  logic signed [DENW+W1-1:0] mdab16 [3];

  for (genvar k = 0; k < 3; k++) begin : g_l4
    bssp_mul #(.AW(DENW), .BW(W1)) u_mdab (.clk, .en(en[16:14]), .a(den13), .b(fab13[k]),
                                           .p(mdab16[k]));
    bssp_dly #(.W(TW), .N(3)) u_dt (.clk, .en(en[16:14]), .d(t13[k]), .q(t16[k]));
  end

  // Stage 17
  logic signed [TMW-1:0] term17 [3];

  always_ff @(posedge clk) begin
    if (en[17]) begin
      for (int k = 0; k < 3; k++) begin
        term17[k] <= TMW'(t16[k]) - TMW'(mdab16[k]);
      end
    end
  end

  // Stages 18 to 20: last multiplier level
  logic signed [W1+TMW-1:0] mres20 [3];

  for (genvar k = 0; k < 3; k++) begin : g_l5
    bssp_mul #(.AW(W1), .BW(TMW)) u_mres (.clk, .en(en[20:18]), .a(amb17[k]), .b(term17[k]),
                                          .p(mres20[k]));
  end

  // Stage 21
  logic signed [RSW-1:0] res21;

  always_ff @(posedge clk) begin
    if (en[21]) begin
      res21 <= RSW'(mres20[0]) + RSW'(mres20[1]) + RSW'(mres20[2]);
    end
  end

  // Stage 22: case selection and output word
  side_t side_next, side22;

  always_comb begin
    case (op21)
      OP_VERTEX: side_next = sv21;
      OP_EDGE:   side_next = se21;
      default:   side_next = side_mul(side_of(res21[RSW-1], |res21),
                                      side_of(den21[DENW-1], |den21));
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[22]) begin
      side22 <= side_next;
    end
  end

  assign m_tvalid = v[NSTG];
  assign m_tdata  = {{(OUT_TDATA_W-SIDE_W){1'b0}}, side22};

endmodule

`default_nettype wire

[sim/bisector_side_sign_predicate_tb.sv]
// ----------------------------------------------------------------------------
// Bisector side sign predicate testbench
// Drives vertex, edge and facet queries through the stream input in random
// bursts, predicts each side sign with exact wide integer arithmetic and
// compares the result words in order, under a randomly stalling receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bisector_side_sign_predicate_tb;
  import bssp_pkg::*;

  localparam int CB        = COORD_BITS_DEF;
  localparam int N_RANDOM  = 740;
  localparam int MAX_CYCLE = 400000;

  typedef logic signed [255:0] wint;
  typedef logic [IN_TDATA_W-1:0] query_t;

  class side_scoreboard;
    side_t pending[$];
    int    errors;

    function wint coord(logic [FIELD_W-1:0] p, int k);
      logic signed [CB-1:0] t;
      wint r;
      t = p[k*CB +: CB];
      r = t;
      return r;
    endfunction

    function wint dot3(wint x0, wint x1, wint x2, wint y0, wint y1, wint y2);
      return x0 * y0 + x1 * y1 + x2 * y2;
    endfunction

    function side_t sign_of(wint v);
      if (v < 0) return SIDE_NEG;
      if (v != 0) return SIDE_POS;
      return SIDE_ZERO;
    endfunction

    function side_t sign_times(side_t x, side_t y);
      if (x == SIDE_ZERO || y == SIDE_ZERO) return SIDE_ZERO;
      return (x == y) ? SIDE_POS : SIDE_NEG;
    endfunction

    function side_t predict_side(query_t w);
      wint a[3], b[3], c[3], d[3], q1[3], q2[3], q3[3];
      wint u[3], f[3], v[3], s[3], t[3], e[3], wv[3], sd[3], sc[3];
      wint n[3], g[3], h[3], k[3];
      wint acc, den, res, hd, hc, nq, term;
      logic [OP_W-1:0] op;
      op = w[OP_W-1:0];
      for (int i = 0; i < 3; i++) begin
        a[i]  = coord(w[OP_W + 0*FIELD_W +: FIELD_W], i);
        b[i]  = coord(w[OP_W + 1*FIELD_W +: FIELD_W], i);
        c[i]  = coord(w[OP_W + 2*FIELD_W +: FIELD_W], i);
        d[i]  = coord(w[OP_W + 3*FIELD_W +: FIELD_W], i);
        q1[i] = coord(w[OP_W + 4*FIELD_W +: FIELD_W], i);
        q2[i] = coord(w[OP_W + 5*FIELD_W +: FIELD_W], i);
        q3[i] = coord(w[OP_W + 6*FIELD_W +: FIELD_W], i);
      end
      if (op == OP_VERTEX) begin
        acc = 0;
        for (int i = 0; i < 3; i++)
          acc = acc + (a[i] - b[i]) * (q1[i] + q1[i] - a[i] - b[i]);
        return sign_of(acc);
      end else if (op == OP_EDGE) begin
        for (int i = 0; i < 3; i++) begin
          u[i] = q2[i] - q1[i];
          f[i] = a[i] - c[i];
          v[i] = a[i] - b[i];
          s[i] = c[i] + a[i] - (q1[i] + q1[i]);
          t[i] = q1[i] + q1[i] - (b[i] + a[i]);
        end
        den = dot3(u[0], u[1], u[2], f[0], f[1], f[2]);
        res = dot3(v[0], v[1], v[2], u[0], u[1], u[2])
              * dot3(s[0], s[1], s[2], f[0], f[1], f[2])
              + dot3(v[0], v[1], v[2], t[0], t[1], t[2]) * den;
        return sign_times(sign_of(res), sign_of(den));
      end
      // The facet case, also taken by the unused fourth operation code.
      for (int i = 0; i < 3; i++) begin
        e[i]  = d[i] - a[i];
        f[i]  = c[i] - a[i];
        u[i]  = q2[i] - q1[i];
        wv[i] = q3[i] - q1[i];
        sd[i] = a[i] + d[i];
        sc[i] = a[i] + c[i];
      end
      hd = dot3(e[0], e[1], e[2], sd[0], sd[1], sd[2]);
      hc = dot3(f[0], f[1], f[2], sc[0], sc[1], sc[2]);
      for (int i = 0; i < 3; i++) begin
        n[i] = u[(i+1)%3] * wv[(i+2)%3] - u[(i+2)%3] * wv[(i+1)%3];
      end
      for (int i = 0; i < 3; i++) begin
        g[i] = e[(i+1)%3] * n[(i+2)%3] - e[(i+2)%3] * n[(i+1)%3];
        h[i] = n[(i+1)%3] * f[(i+2)%3] - n[(i+2)%3] * f[(i+1)%3];
        k[i] = f[(i+1)%3] * e[(i+2)%3] - f[(i+2)%3] * e[(i+1)%3];
      end
      nq  = dot3(n[0], n[1], n[2], q1[0], q1[1], q1[2]);
      nq  = nq + nq;
      den = dot3(f[0], f[1], f[2], g[0], g[1], g[2]);
      res = 0;
      for (int i = 0; i < 3; i++) begin
        term = g[i] * hc + h[i] * hd + k[i] * nq - den * (a[i] + b[i]);
        res  = res + (a[i] - b[i]) * term;
      end
      return sign_times(sign_of(res), sign_of(den));
    endfunction

    task report(string what);
      $display("MISMATCH at %0t: %s", $time, what);
      errors++;
    endtask

    function void note_query(query_t w);
      pending.push_back(predict_side(w));
    endfunction

    task check_result(logic [OUT_TDATA_W-1:0] word);
      side_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result word %h", word));
        return;
      end
      want = pending.pop_front();
      if (word[SIDE_W-1:0] !== want)
        report($sformatf("side_sign %b, expected %b", word[SIDE_W-1:0], want));
      if (word[OUT_TDATA_W-1:SIDE_W] !== '0)
        report($sformatf("fill bits of result word %h not zero", word));
    endtask
  endclass

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [IN_TDATA_W-1:0] s_tdata;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  side_scoreboard sides;
  int accepted_n = 0;
  int cycle_n = 0;
  int stall_left;
  int rx_mode;
  bit long_hold_done = 1'b0;

  bisector_side_sign_predicate uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  localparam int CMAX = 2 ** (CB - 1) - 1;
  localparam int CMIN = -(2 ** (CB - 1));

  function automatic logic [FIELD_W-1:0] point(int x, int y, int z);
    return {CB'(z), CB'(y), CB'(x)};
  endfunction

  function automatic int rand_coord();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) return int'($urandom_range(0, 15)) - 8;
    if (pick < 8) return int'($urandom);
    return pick == 8 ? CMAX : CMIN;
  endfunction

  function automatic logic [FIELD_W-1:0] rand_point();
    return point(rand_coord(), rand_coord(), rand_coord());
  endfunction

  function automatic query_t make_query(logic [OP_W-1:0] op,
      logic [FIELD_W-1:0] pa, logic [FIELD_W-1:0] pb, logic [FIELD_W-1:0] pc,
      logic [FIELD_W-1:0] pd, logic [FIELD_W-1:0] p1, logic [FIELD_W-1:0] p2,
      logic [FIELD_W-1:0] p3);
    query_t w;
    w = '0;
    w[OP_W-1:0] = op;
    w[OP_W +: 7*FIELD_W] = {p3, p2, p1, pd, pc, pb, pa};
    return w;
  endfunction

  function automatic query_t rand_query();
    logic [FIELD_W-1:0] pa, pb, pc, pd, p1, p2, p3;
    logic [OP_W-1:0] op;
    int twist;
    op = OP_W'($urandom_range(0, 3));
    pa = rand_point(); pb = rand_point(); pc = rand_point(); pd = rand_point();
    p1 = rand_point(); p2 = rand_point(); p3 = rand_point();
    twist = $urandom_range(0, 15);
    // A few degenerate shapes so that zero answers come up often enough.
    case (twist)
      0: pb = pa;
      1: p2 = p1;
      2: p3 = p2;
      3: pd = pc;
      4: pc = pa;
      default: ;
    endcase
    return make_query(op, pa, pb, pc, pd, p1, p2, p3);
  endfunction

  task automatic send_query(query_t w);
    s_tvalid <= 1'b1;
    s_tdata  <= w;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic maybe_gap();
    if ($urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        sides.note_query(s_tdata);
        accepted_n <= accepted_n + 1;
      end
      if (m_tvalid && m_tready) sides.check_result(m_tdata);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      stall_left <= 0;
      rx_mode    <= 0;
    end else if (stall_left > 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!long_hold_done && accepted_n >= 200) begin
      long_hold_done <= 1'b1;
      stall_left     <= 300;
      m_tready       <= 1'b0;
    end else begin
      if ($urandom_range(0, 63) == 0) rx_mode <= $urandom_range(0, 3);
      case (rx_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= $urandom_range(0, 1);
        2: m_tready <= $urandom_range(0, 7) != 0;
        default: m_tready <= $urandom_range(0, 7) == 0;
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_n <= cycle_n + 1;
    if (cycle_n > MAX_CYCLE) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    logic [FIELD_W-1:0] pmax, pmin, p0;
    sides          = new();
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    pmax = point(CMAX, CMAX, CMAX);
    pmin = point(CMIN, CMIN, CMIN);
    p0   = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Extremes of the coordinates for every operation.
    send_query(make_query(OP_VERTEX, pmax, pmin, p0, p0, pmax, p0, p0));
    send_query(make_query(OP_VERTEX, pmin, pmax, p0, p0, pmin, p0, p0));
    send_query(make_query(OP_VERTEX, pmax, pmin, pmin, pmin, p0, pmax, pmax));
    send_query(make_query(OP_VERTEX, pmax, pmax, p0, p0, pmin, p0, p0));
    send_query(make_query(OP_EDGE, pmax, pmin, pmin, pmax, pmin, pmax, pmin));
    send_query(make_query(OP_EDGE, pmin, pmax, pmax, p0, pmax, pmin, p0));
    send_query(make_query(OP_EDGE, point(CMAX, CMIN, 1), point(CMIN, CMAX, 3),
                          point(CMIN, 5, CMAX), p0, point(1, CMIN, CMAX),
                          point(CMAX, 2, CMIN), p0));
    // Edge of zero length and edge parallel to the bisector.
    send_query(make_query(OP_EDGE, pmax, pmin, pmin, p0, pmax, pmax, p0));
    send_query(make_query(OP_EDGE, point(2, 0, 0), point(0, 5, 0), point(0, 0, 0),
                          p0, point(0, 1, 0), point(0, 4, 3), p0));
    send_query(make_query(OP_FACET, pmax, pmin, point(CMIN, CMAX, CMAX),
                          point(CMAX, CMIN, CMAX), pmin, point(CMAX, CMIN, CMIN),
                          point(CMIN, CMIN, CMAX)));
    send_query(make_query(OP_FACET, point(1, 2, 3), point(-4, 5, 1),
                          point(7, -3, 2), point(0, 6, -5), point(1, 0, 0),
                          point(0, 1, 0), point(0, 0, 1)));
    // Facet with collinear corners, and with coincident defining sites.
    send_query(make_query(OP_FACET, point(1, 2, 3), point(-4, 5, 1),
                          point(7, -3, 2), point(0, 6, -5), point(1, 1, 1),
                          point(2, 2, 2), point(3, 3, 3)));
    send_query(make_query(OP_FACET, point(1, 2, 3), point(-4, 5, 1),
                          point(7, -3, 2), point(7, -3, 2), point(1, 0, 0),
                          point(0, 1, 0), point(0, 0, 1)));
    // The fourth operation code behaves as the facet case.
    send_query(make_query(2'd3, point(1, 2, 3), point(-4, 5, 1),
                          point(7, -3, 2), point(0, 6, -5), point(1, 0, 0),
                          point(0, 1, 0), point(0, 0, 1)));
    send_query(make_query(2'd3, pmax, pmin, pmin, pmax, pmax, pmin, p0));
    s_tvalid <= 1'b0;

    for (int i = 0; i < N_RANDOM; i++) begin
      maybe_gap();
      send_query(rand_query());
    end
    s_tvalid <= 1'b0;

    while (sides.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sides.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[files.f]
src/bssp_pkg.sv
src/bssp_mul.sv
src/bssp_dly.sv
src/bisector_side_sign_predicate.sv
sim/bisector_side_sign_predicate_tb.sv
